>>> hw/rtl/scbc_pkg.sv
// Shared types, codes and default sizes of the size class block cache.
`default_nettype none
package scbc_pkg;

	localparam int ALIGN_BYTES_DEF = 16;
	localparam int CLASS_COUNT_DEF = 64;
	localparam int SLOT_COUNT_DEF  = 64;

	localparam logic [6:0] UNCACHED_TAG    = 7'd64;
	localparam logic [6:0] CACHE_LIMIT_RST = 7'd64;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [2:0] {
		OUT_NULL     = 3'd0,
		OUT_HIT      = 3'd1,
		OUT_FRESH    = 3'd2,
		OUT_UNCACHED = 3'd3,
		OUT_CACHED   = 3'd4,
		OUT_RELEASED = 3'd5
	} outcome_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [31:0] given_handle;
		logic [6:0]  given_class;
		logic        release_valid;
		logic [31:0] release_handle;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_A0,
		ST_A1,
		ST_A2,
		ST_F0,
		ST_F1,
		ST_F2,
		ST_UNLINK,
		ST_CLEAR,
		ST_P0,
		ST_P1,
		ST_LINK,
		ST_HEAD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> hw/rtl/scbc_ram.sv
// Single write port, single registered read port memory with optional written flags.
`default_nettype none
module scbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter bit TRACK = 1'b1
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	input  wire logic [WIDTH-1:0]                       rdefault,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// With TRACK set, an entry that was never written since reset reads as rdefault.
	generate
		if (TRACK) begin : g_track
			logic [DEPTH-1:0] written_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					written_q <= '0;
				end else if (we) begin
					written_q[waddr] <= 1'b1;
				end
			end
			always_ff @(posedge clk) begin
				rdata_q <= written_q[raddr] ? mem_q[raddr] : rdefault;
			end
		end else begin : g_plain
			always_ff @(posedge clk) begin
				rdata_q <= mem_q[raddr];
			end
		end
	endgenerate

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> hw/rtl/scbc_div.sv
// Size class unit that divides the dividend by the power-of-two alignment, rounding down.
`default_nettype none
module scbc_div #(
	parameter int DW    = 10,
	parameter int QW    = 6,
	parameter int ALIGN = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	output logic               done,
	output logic      [QW-1:0] quotient
);
	// The alignment is a power of two, so the class is a plain right shift.
	localparam int SH = (ALIGN > 1) ? $clog2(ALIGN) : 0;

	logic          done_q;
	logic [QW-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= QW'(dividend >> SH);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> hw/rtl/scbc_ctrl.sv
// Sequencer that walks the class stacks, the slot pool and the LRU links.
`default_nettype none
module scbc_ctrl #(
	parameter int ALIGN_BYTES = scbc_pkg::ALIGN_BYTES_DEF,
	parameter int CLASS_COUNT = scbc_pkg::CLASS_COUNT_DEF,
	parameter int SLOT_COUNT  = scbc_pkg::SLOT_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              kind,
	input  wire logic [31:0]       request_size,
	input  wire logic [31:0]       block_handle,
	input  wire logic [6:0]        block_class,
	input  wire logic [6:0]        cache_limit,
	input  wire logic              result_free,
	output logic                   idle,
	output logic                   done,
	output scbc_pkg::result_t      result
);
	import scbc_pkg::*;

	localparam int CIW   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int CPW   = $clog2(CLASS_COUNT + 1);
	localparam int SIW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SPW   = $clog2(SLOT_COUNT + 1);
	localparam int LIMIT = CLASS_COUNT * ALIGN_BYTES;
	localparam int DW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
	localparam logic [CPW-1:0] C_NONE = {CPW{1'b1}};
	localparam logic [SPW-1:0] S_NONE = {SPW{1'b1}};

	state_t state_q, state_d;

	logic [31:0]    handle_q;
	logic [CPW-1:0] c_q, lc_q, p_q, n_q, head_q, tail_q;
	logic [SPW-1:0] s_q, spare_q, total_q;
	logic           is_alloc_q, relink_q;
	result_t        res_q;
	result_t        res_start;

	logic           size_zero, size_over, tag_uncached, div_start, div_done, evict_need;
	logic [CIW-1:0] div_q;

	logic           ct_we, sa_we, sl_we, op_we, on_we;
	logic [CIW-1:0] ct_waddr, op_waddr, on_waddr, cls_raddr;
	logic [SIW-1:0] sa_waddr, sl_waddr, slot_raddr;
	logic [SPW-1:0] ct_wdata, sl_wdata, ct_rdata, sl_rdata, sl_def;
	logic [CPW-1:0] op_wdata, on_wdata, op_rdata, on_rdata;
	logic [31:0]    sa_rdata;
	logic [CPW-1:0] cls_rsel;
	logic [SPW-1:0] slot_rsel;

	assign size_zero    = request_size == 32'd0;
	assign size_over    = 64'(request_size) > 64'(LIMIT);
	assign tag_uncached = 32'(block_class) >= 32'(CLASS_COUNT);
	assign div_start    = (state_q == ST_IDLE) && start && (kind == KIND_ALLOC)
		&& !size_zero && !size_over;
	assign evict_need   = (32'(total_q) >= 32'(cache_limit)) || (spare_q == S_NONE);

	scbc_div #(
		.DW    (DW),
		.QW    (CIW),
		.ALIGN (ALIGN_BYTES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DW'(request_size - 32'd1)),
		.done     (div_done),
		.quotient (div_q)
	);

	// Result of a request that finishes without touching the stores.
	always_comb begin
		res_start = '0;
		if (kind == KIND_ALLOC) begin
			if (size_zero) begin
				res_start.outcome = OUT_NULL;
			end else if (size_over) begin
				res_start.outcome     = OUT_UNCACHED;
				res_start.given_class = UNCACHED_TAG;
			end
		end else if (tag_uncached) begin
			res_start.outcome        = OUT_RELEASED;
			res_start.release_valid  = 1'b1;
			res_start.release_handle = block_handle;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (kind == KIND_ALLOC) begin
						state_d = (size_zero || size_over) ? ST_DONE : ST_DIV;
					end else begin
						state_d = tag_uncached ? ST_DONE : ST_F0;
					end
				end
			end
			ST_DIV:    state_d = div_done ? ST_A0 : ST_DIV;
			ST_A0:     state_d = ST_A1;
			ST_A1:     state_d = (ct_rdata == S_NONE) ? ST_DONE : ST_A2;
			ST_A2:     state_d = ST_UNLINK;
			ST_F0: begin
				if (!evict_need) begin
					state_d = ST_P0;
				end else if (tail_q == C_NONE) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_F1;
				end
			end
			ST_F1:     state_d = (ct_rdata == S_NONE) ? ST_DONE : ST_F2;
			ST_F2:     state_d = (sl_rdata == S_NONE) ? ST_UNLINK : ST_P0;
			ST_UNLINK: state_d = (is_alloc_q && relink_q) ? ST_LINK : ST_CLEAR;
			ST_CLEAR:  state_d = is_alloc_q ? ST_DONE : ST_P0;
			ST_P0:     state_d = ST_P1;
			ST_P1:     state_d = (ct_rdata == S_NONE) ? ST_LINK : ST_DONE;
			ST_LINK:   state_d = ST_HEAD;
			ST_HEAD:   state_d = ST_DONE;
			ST_DONE:   state_d = result_free ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory ports.
	always_comb begin
		ct_we = 1'b0; ct_waddr = lc_q[CIW-1:0]; ct_wdata = sl_rdata;
		sl_we = 1'b0; sl_waddr = s_q[SIW-1:0];  sl_wdata = spare_q;
		sa_we = 1'b0; sa_waddr = spare_q[SIW-1:0];
		op_we = 1'b0; op_waddr = lc_q[CIW-1:0]; op_wdata = C_NONE;
		on_we = 1'b0; on_waddr = lc_q[CIW-1:0]; on_wdata = C_NONE;
		cls_rsel  = (state_q == ST_F0) ? tail_q : c_q;
		slot_rsel = s_q;
		unique case (state_q) inside
			ST_A1, ST_F1: slot_rsel = ct_rdata;
			ST_P0:        slot_rsel = spare_q;
			ST_A2, ST_F2: begin
				ct_we = 1'b1;
				sl_we = 1'b1;
			end
			ST_P1: begin
				ct_we    = 1'b1;
				ct_waddr = c_q[CIW-1:0];
				ct_wdata = spare_q;
				sl_we    = 1'b1;
				sl_waddr = spare_q[SIW-1:0];
				sl_wdata = ct_rdata;
				sa_we    = 1'b1;
			end
			ST_UNLINK: begin
				op_we    = n_q != C_NONE;
				op_waddr = n_q[CIW-1:0];
				op_wdata = p_q;
				on_we    = p_q != C_NONE;
				on_waddr = p_q[CIW-1:0];
				on_wdata = n_q;
			end
			ST_CLEAR: begin
				op_we = 1'b1;
				on_we = 1'b1;
			end
			ST_LINK: begin
				op_we    = 1'b1;
				on_we    = 1'b1;
				on_wdata = head_q;
			end
			ST_HEAD: begin
				op_we    = head_q != C_NONE;
				op_waddr = head_q[CIW-1:0];
				op_wdata = lc_q;
			end
			default: begin
			end
		endcase
		cls_raddr  = cls_rsel[CIW-1:0];
		slot_raddr = slot_rsel[SIW-1:0];
		sl_def     = (32'(slot_raddr) + 32'd1 >= 32'(SLOT_COUNT)) ? S_NONE
			: SPW'(32'(slot_raddr) + 32'd1);
	end

	scbc_ram #(.WIDTH(SPW), .DEPTH(CLASS_COUNT), .TRACK(1'b1)) u_class_top (
		.clk(clk), .arst_n(arst_n), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
		.raddr(cls_raddr), .rdefault(S_NONE), .rdata(ct_rdata)
	);

	scbc_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT), .TRACK(1'b0)) u_slot_addr (
		.clk(clk), .arst_n(arst_n), .we(sa_we), .waddr(sa_waddr), .wdata(handle_q),
		.raddr(slot_raddr), .rdefault(32'd0), .rdata(sa_rdata)
	);

	scbc_ram #(.WIDTH(SPW), .DEPTH(SLOT_COUNT), .TRACK(1'b1)) u_slot_link (
		.clk(clk), .arst_n(arst_n), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(slot_raddr), .rdefault(sl_def), .rdata(sl_rdata)
	);

	scbc_ram #(.WIDTH(CPW), .DEPTH(CLASS_COUNT), .TRACK(1'b1)) u_order_prev (
		.clk(clk), .arst_n(arst_n), .we(op_we), .waddr(op_waddr), .wdata(op_wdata),
		.raddr(cls_raddr), .rdefault(C_NONE), .rdata(op_rdata)
	);

	scbc_ram #(.WIDTH(CPW), .DEPTH(CLASS_COUNT), .TRACK(1'b1)) u_order_next (
		.clk(clk), .arst_n(arst_n), .we(on_we), .waddr(on_waddr), .wdata(on_wdata),
		.raddr(cls_raddr), .rdefault(C_NONE), .rdata(on_rdata)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			spare_q <= '0;
			total_q <= '0;
			head_q  <= C_NONE;
			tail_q  <= C_NONE;
		end else begin
			state_q <= state_d;
			unique case (state_q) inside
				ST_A2, ST_F2: begin
					spare_q <= s_q;
					total_q <= total_q - 1'b1;
				end
				ST_P1: begin
					spare_q <= sl_rdata;
					total_q <= total_q + 1'b1;
				end
				ST_UNLINK: begin
					if (head_q == lc_q) begin
						head_q <= n_q;
					end
					if (tail_q == lc_q) begin
						tail_q <= p_q;
					end
				end
				ST_HEAD: begin
					head_q <= lc_q;
					if (tail_q == C_NONE) begin
						tail_q <= lc_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers and the result being built.
	always_ff @(posedge clk) begin
		case (state_q) inside
			ST_IDLE: begin
				if (start) begin
					res_q      <= res_start;
					handle_q   <= block_handle;
					is_alloc_q <= kind == KIND_ALLOC;
					c_q        <= CPW'(block_class);
				end
			end
			ST_DIV: begin
				if (div_done) begin
					c_q               <= CPW'(div_q);
					lc_q              <= CPW'(div_q);
					res_q.given_class <= 7'(div_q);
				end
			end
			ST_A1, ST_F1: begin
				p_q <= op_rdata;
				n_q <= on_rdata;
				s_q <= ct_rdata;
				if (ct_rdata == S_NONE) begin
					if (state_q == ST_A1) begin
						res_q.outcome <= OUT_FRESH;
					end else begin
						res_q.outcome        <= OUT_RELEASED;
						res_q.release_valid  <= 1'b1;
						res_q.release_handle <= handle_q;
					end
				end
			end
			ST_A2: begin
				res_q.outcome      <= OUT_HIT;
				res_q.given_handle <= sa_rdata;
				relink_q           <= sl_rdata != S_NONE;
			end
			ST_F0: begin
				lc_q <= tail_q;
				if (evict_need && tail_q == C_NONE) begin
					res_q.outcome        <= OUT_RELEASED;
					res_q.release_valid  <= 1'b1;
					res_q.release_handle <= handle_q;
				end
			end
			ST_F2: begin
				res_q.release_valid  <= 1'b1;
				res_q.release_handle <= sa_rdata;
			end
			ST_P1: begin
				lc_q          <= c_q;
				res_q.outcome <= OUT_CACHED;
			end
			default: begin
			end
		endcase
	end

	assign idle   = state_q == ST_IDLE;
	assign done   = state_q == ST_DONE;
	assign result = res_q;

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == C_NONE) == (tail_q == C_NONE))
		else $error("LRU head and tail disagree on emptiness");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= 32'(SLOT_COUNT))
		else $error("cached count exceeds slot pool");

	a_pool_full: assert property (@(posedge clk) disable iff (!arst_n)
		(spare_q == S_NONE) == (32'(total_q) == 32'(SLOT_COUNT)))
		else $error("spare slot list out of step with cached count");

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && result_free) |=> state_q == ST_IDLE)
		else $error("finished request not handed over");
endmodule
`default_nettype wire

>>> hw/rtl/size_class_block_cache_top.sv
// Zero, oversize and uncached requests finish without touching the stores; an allocate
// miss finishes sooner than a hit, and a free takes longest when an eviction empties the
// LRU tail class and the freed class joins.
// Requests are taken one at a time; in_ready returns on the edge that loads the result.
// Reset: every class stack, the LRU list and the slot pool read as their reset values
// through per-entry written flags, so no clearing pass is needed; cache_limit is 64.
`default_nettype none
module size_class_block_cache_top #(
	parameter int ALIGN_BYTES = scbc_pkg::ALIGN_BYTES_DEF,
	parameter int CLASS_COUNT = scbc_pkg::CLASS_COUNT_DEF,
	parameter int SLOT_COUNT  = scbc_pkg::SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] request_size,
	input  wire logic [31:0] block_handle,
	input  wire logic [6:0]  block_class,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       outcome,
	output logic [31:0]      given_handle,
	output logic [6:0]       given_class,
	output logic             release_valid,
	output logic [31:0]      release_handle
);
	import scbc_pkg::*;

	logic    [6:0] cache_limit_q;
	logic          out_valid_q;
	result_t       out_q;
	logic          idle, done, result_free;
	result_t       result;

	// Limit writes are taken in any cycle; the user must write only when idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_limit_q <= CACHE_LIMIT_RST;
		end else if (cfg_valid) begin
			cache_limit_q <= cfg_data;
		end
	end

	// The output register lets the sequencer take the next request and run it up to done
	// while the previous result still waits on the downstream side.
	assign result_free = !out_valid_q || out_ready;
	assign in_ready    = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && result_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && result_free) begin
			out_q <= result;
		end
	end

	scbc_ctrl #(
		.ALIGN_BYTES (ALIGN_BYTES),
		.CLASS_COUNT (CLASS_COUNT),
		.SLOT_COUNT  (SLOT_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_valid && idle),
		.kind         (kind),
		.request_size (request_size),
		.block_handle (block_handle),
		.block_class  (block_class),
		.cache_limit  (cache_limit_q),
		.result_free  (result_free),
		.idle         (idle),
		.done         (done),
		.result       (result)
	);

	assign out_valid      = out_valid_q;
	assign outcome        = out_q.outcome;
	assign given_handle   = out_q.given_handle;
	assign given_class    = out_q.given_class;
	assign release_valid  = out_q.release_valid;
	assign release_handle = out_q.release_handle;
endmodule
`default_nettype wire

>>> test/tb_size_class_block_cache_top.sv
// Testbench of the size class block cache: directed table, then random traffic against a predictor.
`default_nettype none
module tb_size_class_block_cache_top;
	import scbc_pkg::*;

	localparam int NCLS = 64;
	localparam int NSLOT = 64;
	localparam logic [6:0] NIL = 7'h7F;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [6:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic kind = KIND_ALLOC;
	logic [31:0] request_size = '0;
	logic [31:0] block_handle = '0;
	logic [6:0] block_class = '0;
	logic out_ready = 1'b0;
	logic cfg_ready, in_ready, out_valid, release_valid;
	logic [2:0] outcome;
	logic [31:0] given_handle, release_handle;
	logic [6:0] given_class;

	size_class_block_cache_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.request_size(request_size), .block_handle(block_handle), .block_class(block_class),
		.out_valid(out_valid), .out_ready(out_ready), .outcome(outcome),
		.given_handle(given_handle), .given_class(given_class),
		.release_valid(release_valid), .release_handle(release_handle)
	);

	always #5 clk = ~clk;

	// Shadow copy of the cache state. NIL marks an empty link, as the hardware's "none".
	logic [6:0] limit_sh;
	logic [6:0] top_sh[NCLS];
	logic [31:0] addr_sh[NSLOT];
	logic [6:0] link_sh[NSLOT];
	logic [6:0] spare_sh;
	logic [6:0] prev_sh[NCLS];
	logic [6:0] next_sh[NCLS];
	logic [6:0] head_sh, tail_sh;
	int unsigned total_sh;

	result_t pending_results[$];
	int errors = 0;
	int checked = 0;
	longint cycles = 0;
	int hits = 0, evictions = 0;

	// Sets the shadow copy to its reset state: empty class stacks and LRU list, the slot pool
	// linked in order and the reset limit. Handle values in the traffic are random.
	task automatic shadow_reset();
		limit_sh = CACHE_LIMIT_RST;
		for (int i = 0; i < NCLS; i++) begin
			top_sh[i] = NIL;
			prev_sh[i] = NIL;
			next_sh[i] = NIL;
		end
		for (int i = 0; i < NSLOT; i++)
			link_sh[i] = (i + 1 < NSLOT) ? 7'(i + 1) : NIL;
		spare_sh = 0;
		head_sh = NIL;
		tail_sh = NIL;
		total_sh = 0;
	endtask

	task automatic lru_link_head(input logic [6:0] c);
		prev_sh[c] = NIL;
		next_sh[c] = head_sh;
		if (head_sh != NIL)
			prev_sh[head_sh] = c;
		head_sh = c;
		if (tail_sh == NIL)
			tail_sh = c;
	endtask

	task automatic lru_unlink(input logic [6:0] c);
		logic [6:0] p, n;
		p = prev_sh[c];
		n = next_sh[c];
		if (p != NIL)
			next_sh[p] = n;
		if (n != NIL)
			prev_sh[n] = p;
		if (head_sh == c)
			head_sh = n;
		if (tail_sh == c)
			tail_sh = p;
		prev_sh[c] = NIL;
		next_sh[c] = NIL;
	endtask

	task automatic stack_pop(input logic [6:0] c, output logic [31:0] h);
		logic [6:0] s;
		s = top_sh[c];
		h = addr_sh[s];
		top_sh[c] = link_sh[s];
		link_sh[s] = spare_sh;
		spare_sh = s;
		total_sh--;
	endtask

	// Works out the result of one request and updates the shadow state.
	task automatic predict_cache_result(input logic k, input logic [31:0] sz,
			input logic [31:0] h, input logic [6:0] tag, output result_t r);
		logic [32:0] units;
		logic [6:0] c, s;
		logic stored, was_empty;
		r = '{outcome: OUT_NULL, default: '0};
		if (k == KIND_ALLOC) begin
			units = ({1'b0, sz} + 33'd15) >> 4;
			if (units == 0) begin
				r.outcome = OUT_NULL;
			end else if (units > NCLS) begin
				r.outcome = OUT_UNCACHED;
				r.given_class = UNCACHED_TAG;
			end else begin
				c = 7'(units - 1);
				r.given_class = c;
				if (top_sh[c] != NIL) begin
					stack_pop(c, r.given_handle);
					lru_unlink(c);
					if (top_sh[c] != NIL)
						lru_link_head(c);
					r.outcome = OUT_HIT;
					hits++;
				end else begin
					r.outcome = OUT_FRESH;
				end
			end
		end else if (tag >= NCLS) begin
			r.outcome = OUT_RELEASED;
			r.release_valid = 1'b1;
			r.release_handle = h;
		end else begin
			stored = 1'b1;
			if (total_sh >= limit_sh || spare_sh == NIL) begin
				c = tail_sh;
				if (c != NIL && top_sh[c] != NIL) begin
					stack_pop(c, r.release_handle);
					r.release_valid = 1'b1;
					evictions++;
					if (top_sh[c] == NIL)
						lru_unlink(c);
				end else begin
					stored = 1'b0;
				end
			end
			if (stored && spare_sh != NIL) begin
				s = spare_sh;
				was_empty = (top_sh[tag] == NIL);
				spare_sh = link_sh[s];
				addr_sh[s] = h;
				link_sh[s] = top_sh[tag];
				top_sh[tag] = s;
				total_sh++;
				if (was_empty)
					lru_link_head(tag);
				r.outcome = OUT_CACHED;
			end else begin
				r.outcome = OUT_RELEASED;
				r.release_valid = 1'b1;
				r.release_handle = h;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
		errors++;
	endtask

	// Receiver: stalls on a pattern of its own, and compares every accepted result.
	int stall_phase = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			// Stretches of full readiness alternate with random stalling.
			out_ready <= (stall_phase % 300 < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		result_t want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(outcome), 0);
			end else begin
				want = pending_results.pop_front();
				if (outcome !== want.outcome)
					report_mismatch("outcome", 32'(outcome), 32'(want.outcome));
				if (given_handle !== want.given_handle)
					report_mismatch("given_handle", given_handle, want.given_handle);
				if (given_class !== want.given_class)
					report_mismatch("given_class", 32'(given_class), 32'(want.given_class));
				if (release_valid !== want.release_valid)
					report_mismatch("release_valid", 32'(release_valid), 32'(want.release_valid));
				if (release_handle !== want.release_handle)
					report_mismatch("release_handle", release_handle, want.release_handle);
			end
			checked <= checked + 1;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Drives one request and waits for its acceptance; the expectation is queued then.
	task automatic send_request(input logic k, input logic [31:0] sz, input logic [31:0] h,
			input logic [6:0] tag);
		result_t r;
		in_valid <= 1'b1;
		kind <= k;
		request_size <= sz;
		block_handle <= h;
		block_class <= tag;
		do @(posedge clk); while (!in_ready);
		predict_cache_result(k, sz, h, tag, r);
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Writes cache_limit while the block is idle.
	task automatic write_limit(input logic [6:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		limit_sh = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	typedef struct {
		logic k;
		logic [31:0] sz;
		logic [31:0] h;
		logic [6:0] tag;
		logic typed;
		outcome_t oc;
		logic [6:0] gc;
	} stim_row_t;

	// Directed rows: extremes, every outcome and uncached tags.
	stim_row_t directed_rows[] = '{
		'{KIND_ALLOC, 32'd0, 32'h0, 7'd0, 1'b1, OUT_NULL, 7'd0},
		'{KIND_ALLOC, 32'd1, 32'h0, 7'd0, 1'b1, OUT_FRESH, 7'd0},
		'{KIND_ALLOC, 32'd1024, 32'h0, 7'd0, 1'b1, OUT_FRESH, 7'd63},
		'{KIND_ALLOC, 32'd1025, 32'h0, 7'd0, 1'b1, OUT_UNCACHED, UNCACHED_TAG},
		'{KIND_ALLOC, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'h7F, 1'b1, OUT_UNCACHED, UNCACHED_TAG},
		'{KIND_FREE, 32'hFFFFFFFF, 32'hDEAD0000, 7'd64, 1'b1, OUT_RELEASED, 7'd0},
		'{KIND_FREE, 32'h0, 32'hFFFFFFFF, 7'h7F, 1'b1, OUT_RELEASED, 7'd0},
		'{KIND_FREE, 32'h0, 32'h00001000, 7'd0, 1'b1, OUT_CACHED, 7'd0},
		'{KIND_FREE, 32'h0, 32'h00002000, 7'd63, 1'b1, OUT_CACHED, 7'd0},
		'{KIND_FREE, 32'h0, 32'h00003000, 7'd0, 1'b0, OUT_NULL, 7'd0},
		'{KIND_ALLOC, 32'd16, 32'h0, 7'd0, 1'b0, OUT_NULL, 7'd0},
		'{KIND_ALLOC, 32'd1009, 32'h0, 7'd0, 1'b0, OUT_NULL, 7'd0},
		'{KIND_ALLOC, 32'd17, 32'h0, 7'd0, 1'b1, OUT_FRESH, 7'd1},
		'{KIND_FREE, 32'h0, 32'h00004000, 7'd5, 1'b0, OUT_NULL, 7'd0},
		'{KIND_FREE, 32'h0, 32'h00005000, 7'd6, 1'b0, OUT_NULL, 7'd0},
		'{KIND_ALLOC, 32'd96, 32'h0, 7'd0, 1'b0, OUT_NULL, 7'd0}
	};

	task automatic run_directed();
		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].k, directed_rows[i].sz, directed_rows[i].h,
				directed_rows[i].tag);
			// Typed rows must also agree with what was read off the table.
			if (directed_rows[i].typed && (pending_results[$].outcome != directed_rows[i].oc
					|| pending_results[$].given_class != directed_rows[i].gc))
				report_mismatch("directed row", 32'(i), 32'(directed_rows[i].oc));
		end
	endtask

	// Random traffic. Most frees use cached classes, half of them from a narrow spread, so
	// stacks grow deep and the limit forces evictions; the rest is noise.
	task automatic run_random(input int count);
		int burst;
		logic k;
		logic [31:0] sz;
		logic [6:0] tag;
		int sel;
		for (int n = 0; n < count; ) begin
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst && n < count; b++, n++) begin
				k = $urandom_range(0, 1);
				sel = $urandom_range(0, 19);
				if (sel < 14)
					sz = $urandom_range(1, 16 * ($urandom_range(0, 1) ? 8 : 64));
				else if (sel < 16)
					sz = $urandom;
				else if (sel < 17)
					sz = 0;
				else
					sz = $urandom_range(1000, 1100);
				if (sel < 17)
					tag = ($urandom_range(0, 1)) ? 7'($urandom_range(0, 7))
						: 7'($urandom_range(0, 63));
				else
					tag = 7'($urandom_range(64, 127));
				send_request(k, sz, $urandom, tag);
			end
			if ($urandom_range(0, 2) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	endtask

	initial begin
		shadow_reset();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		// Lower the limit to one and check that eviction goes one per free.
		write_limit(7'd1);
		send_request(KIND_FREE, 32'h0, 32'h0000A000, 7'd2);
		send_request(KIND_FREE, 32'h0, 32'h0000B000, 7'd3);
		run_random(300);
		write_limit(7'd127);
		run_random(300);
		write_limit(7'd0);
		send_request(KIND_FREE, 32'h0, 32'h0000C000, 7'd4);
		run_random(150);
		write_limit(7'd8);
		run_random(250);
		// The sender holds off here until every result has come back.
		drain_results();
		write_limit(7'd64);
		run_random(250);
		drain_results();
		$display("Covered %0d results, %0d cache hits and %0d evictions", checked, hits,
			evictions);
		$display("Limits written: 1, 127, 0, 8 and 64; %0d mismatches", errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
